// File: hdl/jlf_pkg.sv
package jlf_pkg;

  localparam int MAX_LINE = 64;
  localparam int ADDR_W   = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
  localparam int FILL_W   = $clog2(MAX_LINE + 1);
  localparam int DROP_W   = 16;

  localparam logic [7:0] NL_BYTE    = 8'h0A;
  localparam logic [7:0] BRACE_BYTE = 8'h7B;
  localparam logic [7:0] SP_BYTE    = 8'h20;
  localparam logic [7:0] TAB_BYTE   = 8'h09;
  localparam logic [7:0] CR_BYTE    = 8'h0D;

  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_LINE);
  localparam logic [DROP_W-1:0] DROP_MAX = '1;

  typedef logic [ADDR_W-1:0] addr_t;

  // Request from the collector to the line emitter.
  typedef struct packed {
    logic  start;
    addr_t first;
    addr_t stop;
  } emit_cmd_t;

  function automatic logic is_trim(input logic [7:0] b);
    return (b == SP_BYTE) || (b == TAB_BYTE) || (b == CR_BYTE) || (b == NL_BYTE);
  endfunction

endpackage

// File: hdl/jlf_line_ram.sv
module jlf_line_ram (
  input  logic              clk,
  input  logic              we,
  input  jlf_pkg::addr_t    waddr,
  input  logic [7:0]        wdata,
  input  logic              re,
  input  jlf_pkg::addr_t    raddr,
  output logic [7:0]        rdata
);

  logic [7:0] mem [jlf_pkg::MAX_LINE];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/jlf_emit.sv
module jlf_emit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  jlf_pkg::emit_cmd_t          cmd,
  input  logic [jlf_pkg::DROP_W-1:0]  drop_count,
  output logic                        busy,
  output logic                        rd_en,
  output jlf_pkg::addr_t              rd_addr,
  input  logic [7:0]                  rd_data,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [23:0]                 out_tdata,
  output logic                        out_tlast
);

  typedef enum logic [1:0] {
    EM_IDLE = 2'b01,
    EM_RUN  = 2'b10
  } em_state_t;

  em_state_t      state_r, state_nxt;
  jlf_pkg::addr_t ptr_r, ptr_nxt;
  jlf_pkg::addr_t stop_r, stop_nxt;
  logic           pend_r, pend_nxt;
  logic           pend_last_r, pend_last_nxt;
  logic           ov_r, ov_nxt;
  logic [7:0]     byte_r;
  logic [jlf_pkg::DROP_W-1:0] drop_r;
  logic           tlast_r;
  logic           issue;

  // A read goes out only when the output word is free by the time data returns.
  assign issue   = (state_r == EM_RUN) && !pend_r && (!ov_r || out_tready);
  assign rd_en   = issue;
  assign rd_addr = ptr_r;
  assign busy    = (state_r == EM_RUN) || pend_r;

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    stop_nxt      = stop_r;
    pend_nxt      = 1'b0;
    pend_last_nxt = pend_last_r;
    ov_nxt        = ov_r;
    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end
    if (pend_r) begin
      ov_nxt = 1'b1;
    end
    unique case (state_r)
      EM_IDLE: begin
        if (cmd.start) begin
          state_nxt = EM_RUN;
          ptr_nxt   = cmd.first;
          stop_nxt  = cmd.stop;
        end
      end
      EM_RUN: begin
        if (issue) begin
          pend_nxt      = 1'b1;
          pend_last_nxt = (ptr_r == stop_r);
          ptr_nxt       = ptr_r + 1'b1;
          if (ptr_r == stop_r) begin
            state_nxt = EM_IDLE;
          end
        end
      end
      default: state_nxt = EM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= EM_IDLE;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
    end
    ptr_r       <= ptr_nxt;
    stop_r      <= stop_nxt;
    pend_last_r <= pend_last_nxt;
    if (pend_r) begin
      byte_r  <= rd_data;
      tlast_r <= pend_last_r;
      drop_r  <= drop_count;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {drop_r, byte_r};
  assign out_tlast  = tlast_r;

endmodule

// File: hdl/json_line_framer.sv
// Newline-delimited line framer.
// The input stream carries one received byte per word (in_tdata[7:0]). Bytes
// are collected in a line buffer; a newline closes the line. The line is
// trimmed of leading and trailing space, tab and CR, and if what remains
// starts with '{' its bytes are sent on the output stream in order, with
// out_tlast on the final byte. Empty, blank and non-brace lines give nothing.
// A line longer than MAX_LINE bytes is dropped, the saturating drop count
// goes up, and input is skipped up to the next newline. Every output word
// carries, next to the byte, the drop count sampled when the byte is read back.
// Throughput: while a line is collected, one byte is taken per cycle. After a
// newline that releases a line, the input is held off while the emitter reads
// the buffer back through the registered read of the line memory, issuing a
// new read only once the previous byte is captured. Between the newline and
// the first word lie the emitter state, memory read and output registers.
// If the receiver stalls, the emitter waits with the word held in its output
// register; the input stays stalled until the whole line has been read out.
// The input is taken again while the final word still waits to be taken.
// Reset (rst_n low at a clock edge) empties the line, leaves discard mode and
// clears the drop count; the buffer contents need no clearing.
module json_line_framer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] out_byte, [23:8] dropped_lines
  output logic        out_tlast   // last_byte
);

  logic [jlf_pkg::FILL_W-1:0] fill_r, fill_nxt;
  logic                       discard_r, discard_nxt;
  logic [jlf_pkg::DROP_W-1:0] drop_r, drop_nxt;
  logic                       has_nt_r, has_nt_nxt;
  logic                       brace_r, brace_nxt;
  jlf_pkg::addr_t             first_r, first_nxt;
  jlf_pkg::addr_t             lastnt_r, lastnt_nxt;

  jlf_pkg::emit_cmd_t cmd;
  logic               busy;
  logic               accept;
  logic               we;
  jlf_pkg::addr_t     waddr;
  logic               rd_en;
  jlf_pkg::addr_t     rd_addr;
  logic [7:0]         rd_data;

  assign in_tready = !busy;
  assign accept    = in_tvalid && in_tready;
  assign waddr     = fill_r[jlf_pkg::ADDR_W-1:0];

  // Positions of the first and last non-trim byte are tracked on the way in,
  // so the line end needs no scan of the buffer.
  always_comb begin
    fill_nxt    = fill_r;
    discard_nxt = discard_r;
    drop_nxt    = drop_r;
    has_nt_nxt  = has_nt_r;
    brace_nxt   = brace_r;
    first_nxt   = first_r;
    lastnt_nxt  = lastnt_r;
    we          = 1'b0;
    cmd.start   = 1'b0;
    cmd.first   = first_r;
    cmd.stop    = lastnt_r;
    if (accept) begin
      if (in_tdata == jlf_pkg::NL_BYTE) begin
        if (discard_r) begin
          discard_nxt = 1'b0;
        end else if (has_nt_r && brace_r) begin
          cmd.start = 1'b1;
        end
        fill_nxt   = '0;
        has_nt_nxt = 1'b0;
      end else if (!discard_r) begin
        if (fill_r == jlf_pkg::FILL_MAX) begin
          fill_nxt    = '0;
          discard_nxt = 1'b1;
          has_nt_nxt  = 1'b0;
          if (drop_r != jlf_pkg::DROP_MAX) begin
            drop_nxt = drop_r + 1'b1;
          end
        end else begin
          we       = 1'b1;
          fill_nxt = fill_r + 1'b1;
          if (!jlf_pkg::is_trim(in_tdata)) begin
            if (!has_nt_r) begin
              has_nt_nxt = 1'b1;
              first_nxt  = waddr;
              brace_nxt  = (in_tdata == jlf_pkg::BRACE_BYTE);
            end
            lastnt_nxt = waddr;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      discard_r <= 1'b0;
      drop_r    <= '0;
      has_nt_r  <= 1'b0;
    end else begin
      fill_r    <= fill_nxt;
      discard_r <= discard_nxt;
      drop_r    <= drop_nxt;
      has_nt_r  <= has_nt_nxt;
    end
    brace_r  <= brace_nxt;
    first_r  <= first_nxt;
    lastnt_r <= lastnt_nxt;
  end

  jlf_line_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_tdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  jlf_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .drop_count (drop_r),
    .busy       (busy),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// File: tb/sv/tb_json_line_framer.sv
`timescale 1ns / 100ps

module tb_json_line_framer;

  localparam int RANDOM_ITEMS = 430;
  localparam int IDLE_LIMIT   = 3000;
  localparam int TAIL_CYCLES  = 200;

  typedef struct packed {
    logic [7:0]                 data;
    logic                       last;
    logic [jlf_pkg::DROP_W-1:0] drops;
  } framed_word_t;

  // Tracks the line buffer the same way the framer does and keeps the bytes
  // that the closed lines are due to release.
  class line_tracker;
    logic [7:0]                 held [jlf_pkg::MAX_LINE];
    int                         fill;
    bit                         skipping;
    logic [jlf_pkg::DROP_W-1:0] drops;
    framed_word_t               expected_words [$];
    int                         errors;

    function new();
      fill     = 0;
      skipping = 0;
      drops    = '0;
      errors   = 0;
    endfunction

    function bit blank_byte(logic [7:0] b);
      return b == jlf_pkg::SP_BYTE || b == jlf_pkg::TAB_BYTE || b == jlf_pkg::CR_BYTE ||
             b == jlf_pkg::NL_BYTE;
    endfunction

    function void release_line();
      int head;
      int tail;
      framed_word_t w;
      head = 0;
      while (head < fill && blank_byte(held[head])) head++;
      if (head >= fill || held[head] != jlf_pkg::BRACE_BYTE) return;
      tail = fill;
      while (tail > head && blank_byte(held[tail-1])) tail--;
      for (int k = head; k < tail; k++) begin
        w.data  = held[k];
        w.last  = (k + 1 == tail);
        w.drops = drops;
        expected_words.insert(expected_words.size(), w);
      end
    endfunction

    function void note_byte(logic [7:0] b);
      if (b == jlf_pkg::NL_BYTE) begin
        if (skipping) skipping = 0;
        else release_line();
        fill = 0;
      end else if (!skipping) begin
        if (fill >= jlf_pkg::MAX_LINE) begin
          // The line is too long: throw it away and skip to the newline.
          fill     = 0;
          skipping = 1;
          if (drops != jlf_pkg::DROP_MAX) drops++;
        end else begin
          held[fill] = b;
          fill++;
        end
      end
    endfunction

    function void check_word(logic [7:0] data, logic last,
                             logic [jlf_pkg::DROP_W-1:0] seen_drops);
      framed_word_t w;
      if (expected_words.size() == 0) begin
        $display("%0t: output word with none expected: byte %h last %b drops %0d",
                 $time, data, last, seen_drops);
        errors++;
        return;
      end
      w = expected_words.pop_front();
      if (data !== w.data) begin
        $display("%0t: out_byte expected %h actual %h", $time, w.data, data);
        errors++;
      end
      if (last !== w.last) begin
        $display("%0t: last_byte expected %b actual %b", $time, w.last, last);
        errors++;
      end
      if (seen_drops !== w.drops) begin
        $display("%0t: dropped_lines expected %0d actual %0d", $time, w.drops, seen_drops);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_words.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tlast;

  line_tracker tracker;
  logic [7:0]  line_bytes [$];
  bit          calm;
  int          rx_hold;
  int          idle_cycles;

  json_line_framer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one; none at all while calm.
  function automatic int next_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] random_blank();
    case ($urandom_range(0, 2))
      0: return jlf_pkg::SP_BYTE;
      1: return jlf_pkg::TAB_BYTE;
      default: return jlf_pkg::CR_BYTE;
    endcase
  endfunction

  function automatic logic [7:0] random_text();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == jlf_pkg::NL_BYTE);
    return b;
  endfunction

  function automatic void append_byte(input logic [7:0] b);
    line_bytes.insert(line_bytes.size(), b);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    tracker.note_byte(b);
  endtask

  task automatic send_line();
    foreach (line_bytes[i]) send_byte(line_bytes[i]);
    line_bytes.delete();
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (tracker.outstanding() > 0) @(posedge clk);
  endtask

  task automatic build_brace_line(input int lead, input int body, input int trail);
    line_bytes.delete();
    repeat (lead) append_byte(random_blank());
    append_byte(jlf_pkg::BRACE_BYTE);
    repeat (body - 1) append_byte(random_text());
    repeat (trail) append_byte(random_blank());
    append_byte(jlf_pkg::NL_BYTE);
  endtask

  task automatic build_random_line(input int line_no);
    int kind;
    int lead;
    int trail;
    kind  = $urandom_range(0, 99);
    lead  = $urandom_range(0, 2);
    trail = $urandom_range(0, 2);
    if (line_no == 0) kind = 70;
    if (line_no == 1) kind = 62;
    line_bytes.delete();
    if (kind < 62) begin
      build_brace_line(lead, $urandom_range(1, 10), trail);
    end else if (kind < 70) begin
      // Long lines, often exactly filling the buffer.
      if (line_no == 1 || $urandom_range(0, 1))
        build_brace_line(lead, jlf_pkg::MAX_LINE - lead - trail, trail);
      else
        build_brace_line(lead, $urandom_range(40, jlf_pkg::MAX_LINE - lead - trail), trail);
    end else if (kind < 78) begin
      // Over-long: the byte after a full buffer drops the line.
      if ($urandom_range(0, 1)) append_byte(jlf_pkg::BRACE_BYTE);
      repeat ($urandom_range(jlf_pkg::MAX_LINE + 1, jlf_pkg::MAX_LINE + 8))
        append_byte(random_text());
      append_byte(jlf_pkg::NL_BYTE);
    end else if (kind < 86) begin
      logic [7:0] b;
      repeat (lead) append_byte(random_blank());
      do b = random_text();
      while (b == jlf_pkg::BRACE_BYTE || b == jlf_pkg::SP_BYTE || b == jlf_pkg::TAB_BYTE ||
             b == jlf_pkg::CR_BYTE);
      append_byte(b);
      repeat ($urandom_range(0, 8)) append_byte(random_text());
      append_byte(jlf_pkg::NL_BYTE);
    end else if (kind < 92) begin
      repeat ($urandom_range(0, 4)) append_byte(random_blank());
      append_byte(jlf_pkg::NL_BYTE);
    end else begin
      repeat ($urandom_range(1, 8)) append_byte(8'($urandom_range(0, 255)));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_hold = 0;
    end else if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold--;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) rx_hold = next_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.check_word(out_tdata[7:0], out_tlast, out_tdata[23:8]);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int items;
    int line_no;
    tracker     = new();
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'h00;
    out_tready  = 1'b0;
    calm        = 1'b0;
    idle_cycles = 0;
    rx_hold     = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty line, blank line, a line that does not open with a brace.
    line_bytes = '{jlf_pkg::NL_BYTE};
    send_line();
    line_bytes = '{jlf_pkg::SP_BYTE, jlf_pkg::TAB_BYTE, jlf_pkg::CR_BYTE, jlf_pkg::NL_BYTE};
    send_line();
    line_bytes = '{jlf_pkg::SP_BYTE, 8'h78, jlf_pkg::BRACE_BYTE, jlf_pkg::NL_BYTE};
    send_line();
    // Trimmed on both sides, carrying the byte extremes.
    line_bytes = '{jlf_pkg::SP_BYTE, jlf_pkg::TAB_BYTE, jlf_pkg::BRACE_BYTE, 8'h00, 8'hFF,
                   jlf_pkg::TAB_BYTE, jlf_pkg::CR_BYTE, jlf_pkg::NL_BYTE};
    send_line();
    // A lone brace, then blanks kept inside the line.
    line_bytes = '{jlf_pkg::BRACE_BYTE, jlf_pkg::NL_BYTE};
    send_line();
    line_bytes = '{jlf_pkg::BRACE_BYTE, jlf_pkg::SP_BYTE, jlf_pkg::TAB_BYTE, 8'h7D,
                   jlf_pkg::NL_BYTE};
    send_line();
    wait_drained();

    items   = 0;
    line_no = 0;
    while (items < RANDOM_ITEMS) begin
      build_random_line(line_no);
      calm = ($urandom_range(0, 5) == 0);
      // Bytes skipped after an overflow leave the framer untouched.
      items += (line_bytes.size() > jlf_pkg::MAX_LINE + 2) ? jlf_pkg::MAX_LINE + 2 :
                                                             line_bytes.size();
      send_line();
      if ($urandom_range(0, 11) == 0) wait_drained();
      line_no++;
    end
    // Close whatever noise may have left open.
    line_bytes = '{jlf_pkg::NL_BYTE};
    send_line();
    calm = 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/jlf_pkg.sv
hdl/jlf_line_ram.sv
hdl/jlf_emit.sv
hdl/json_line_framer.sv
tb/sv/tb_json_line_framer.sv
